### rtl/utf16_to_utf8_transcoder_macros.svh
// utf16_to_utf8_transcoder_macros.svh
// assertion macros used by the transcoder back end (u16u8_back), no dependencies
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define U16U8_AST_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define U16U8_AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/u16u8_pkg.sv
// u16u8_pkg.sv
// types and constants for the utf-16 to utf-8 transcoder, no dependencies
`default_nettype none

package u16u8_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LONE_LOW = 2'd1;
    localparam logic [1:0] ST_UNPAIRED = 2'd2;

    localparam logic [5:0] HIGH_TAG = 6'b110110;
    localparam logic [5:0] LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  nb_m1;
        logic [1:0]  status;
        logic        last;
    } t_job;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       str_end;
        logic [1:0] status;
    } t_beat;

endpackage

`default_nettype wire

### rtl/u16u8_queue.sv
// u16u8_queue.sv
// small register queue of decoded jobs between front and back
// depends on u16u8_pkg
`default_nettype none

module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire u16u8_pkg::t_job i_data,
    output logic             o_full,
    input  wire              i_pop,
    output u16u8_pkg::t_job  o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    u16u8_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/u16u8_front.sv
// u16u8_front.sv
// accepts code units, pairs surrogates, flags errors and issues encode jobs
// depends on u16u8_pkg
`default_nettype none

module u16u8_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire [15:0]       i_unit,
    input  wire              i_last,
    output logic             o_ready,
    input  wire              i_q_full,
    output logic             o_push,
    output u16u8_pkg::t_job  o_job
);

    logic [9:0] r_held_bits, n_held_bits;
    logic       r_held, n_held;
    logic       r_discard, n_discard;
    logic       accept, is_high, is_low;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign is_high = (i_unit[15:10] == u16u8_pkg::HIGH_TAG);
    assign is_low  = (i_unit[15:10] == u16u8_pkg::LOW_TAG);

    always_comb begin
        n_held_bits  = r_held_bits;
        n_held       = r_held;
        n_discard    = r_discard;
        o_push       = 1'b0;
        o_job.cp     = {5'd0, i_unit};
        o_job.nb_m1  = 2'd0;
        o_job.status = u16u8_pkg::ST_OK;
        o_job.last   = i_last;
        if (i_unit[15:7] == '0) begin
            o_job.nb_m1 = 2'd0;
        end else if (i_unit[15:11] == '0) begin
            o_job.nb_m1 = 2'd1;
        end else begin
            o_job.nb_m1 = 2'd2;
        end
        if (accept) begin
            if (r_discard) begin
                n_discard = !i_last;
            end else if (r_held) begin
                n_held      = 1'b0;
                n_held_bits = '0;
                o_push      = 1'b1;
                if (is_low) begin
                    o_job.cp    = {1'b0, r_held_bits, i_unit[9:0]} + u16u8_pkg::SUPP_BASE;
                    o_job.nb_m1 = 2'd3;
                end else begin
                    o_job.cp     = '0;
                    o_job.nb_m1  = 2'd0;
                    o_job.status = u16u8_pkg::ST_UNPAIRED;
                    o_job.last   = 1'b1;
                    n_discard    = !i_last;
                end
            end else if (is_low) begin
                o_push       = 1'b1;
                o_job.cp     = '0;
                o_job.nb_m1  = 2'd0;
                o_job.status = u16u8_pkg::ST_LONE_LOW;
                o_job.last   = 1'b1;
                n_discard    = !i_last;
            end else if (is_high) begin
                if (i_last) begin
                    o_push       = 1'b1;
                    o_job.cp     = '0;
                    o_job.nb_m1  = 2'd0;
                    o_job.status = u16u8_pkg::ST_UNPAIRED;
                end else begin
                    n_held      = 1'b1;
                    n_held_bits = i_unit[9:0];
                end
            end else begin
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bits <= '0;
            r_held      <= 1'b0;
            r_discard   <= 1'b0;
        end else begin
            r_held_bits <= n_held_bits;
            r_held      <= n_held;
            r_discard   <= n_discard;
        end
    end

endmodule

`default_nettype wire

### rtl/u16u8_back.sv
// u16u8_back.sv
// takes encode jobs from the queue and emits utf-8 bytes through an output register
// depends on u16u8_pkg and utf16_to_utf8_transcoder_macros.svh
`default_nettype none
`include "utf16_to_utf8_transcoder_macros.svh"

module u16u8_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_empty,
    input  wire u16u8_pkg::t_job i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output u16u8_pkg::t_beat o_beat
);

    u16u8_pkg::t_job  r_job;
    u16u8_pkg::t_beat r_out;
    u16u8_pkg::t_beat beat;
    logic       r_job_valid, n_job_valid;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_idx, n_idx;
    logic       out_free, job_done;

    function automatic logic [7:0] byte_at(input logic [20:0] cp, input logic [1:0] nb_m1,
                                           input logic [1:0] idx);
        logic [7:0] b;
        b = {2'b10, cp[5:0]};
        case (nb_m1)
            2'd0: b = {1'b0, cp[6:0]};
            2'd1: begin
                if (idx == 2'd0) b = {3'b110, cp[10:6]};
            end
            2'd2: begin
                if (idx == 2'd0) b = {4'b1110, cp[15:12]};
                else if (idx == 2'd1) b = {2'b10, cp[11:6]};
            end
            default: begin
                if (idx == 2'd0) b = {5'b11110, cp[20:18]};
                else if (idx == 2'd1) b = {2'b10, cp[17:12]};
                else if (idx == 2'd2) b = {2'b10, cp[11:6]};
            end
        endcase
        return b;
    endfunction

    assign out_free = !r_out_valid || i_ready;
    assign job_done = r_job_valid && out_free && (r_idx == r_job.nb_m1);
    assign o_pop    = !i_q_empty && (!r_job_valid || job_done);
    assign o_valid  = r_out_valid;
    assign o_beat   = r_out;

    always_comb begin
        beat.data    = (r_job.status == u16u8_pkg::ST_OK)
                     ? byte_at(r_job.cp, r_job.nb_m1, r_idx) : 8'd0;
        beat.run_end = (r_idx == r_job.nb_m1);
        beat.str_end = (r_idx == r_job.nb_m1) && r_job.last;
        beat.status  = r_job.status;
    end

    always_comb begin
        n_job_valid = r_job_valid;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = r_job_valid;
        end
        if (o_pop) begin
            n_job_valid = 1'b1;
            n_idx       = '0;
        end else begin
            if (job_done) begin
                n_job_valid = 1'b0;
            end
            if (r_job_valid && out_free) begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_job_valid <= n_job_valid;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (out_free && r_job_valid) begin
            r_out <= beat;
        end
    end

    `U16U8_AST_NOW(a_err_beat, i_clk, i_rst_n,
        r_out_valid && (r_out.status != u16u8_pkg::ST_OK),
        (r_out.data == 8'd0) && r_out.run_end && r_out.str_end, "malformed error beat")
    `U16U8_AST_NOW(a_str_end, i_clk, i_rst_n, r_out_valid && r_out.str_end,
        r_out.run_end, "string end inside a run")
    `U16U8_AST_NOW(a_idx_range, i_clk, i_rst_n, r_job_valid,
        r_idx <= r_job.nb_m1, "byte index past job length")
    `U16U8_AST_NOW(a_err_len, i_clk, i_rst_n,
        r_job_valid && (r_job.status != u16u8_pkg::ST_OK),
        r_job.nb_m1 == 2'd0, "error job longer than one beat")
    `U16U8_AST_NEXT(a_run_gapless, i_clk, i_rst_n, r_out_valid && !r_out.run_end && i_ready,
        r_out_valid, "bubble inside a multi-byte run")

endmodule

`default_nettype wire

### rtl/utf16_to_utf8_transcoder.sv
// utf16_to_utf8_transcoder.sv
// top level: front decoder, job queue and byte emitter
// depends on u16u8_pkg, u16u8_queue, u16u8_front, u16u8_back
//
// usage:
//   slave channel: one utf-16 code unit per beat in s_tdata, s_tlast marks the
//   final unit of a string. master channel: one utf-8 byte per beat in m_tdata,
//   m_tlast marks the final beat of a string, m_tuser carries last_of_run in
//   bit 0 and the status code in bits 2:1 (0 ok, 1 lone low surrogate,
//   2 unpaired high surrogate). an error gives one zero byte and the rest of
//   its string is dropped.
//   an accepted unit passes through the job queue, the job register and the
//   output register. a high surrogate gives no output until the next unit of
//   its string arrives. throughput: the emitter sends one byte per cycle while
//   the receiver is ready; a unit gives as many bytes as it needs: 1 for ascii,
//   2 or 3 for other bmp units, 4 per surrogate pair (2 units). units are taken
//   back to back while the job queue has room.
//   reset clears held surrogate, discard state, queue and the job and output valid flags.
//   when the receiver stalls the output beat holds, the queue fills and
//   s_tready falls once it is full.
`default_nettype none

module utf16_to_utf8_transcoder #(
    parameter int QDEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // code_unit
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic [2:0]  m_tuser,   // last_of_run, status[1:0]
    output logic        m_tlast
);

    u16u8_pkg::t_job  push_job, pop_job;
    u16u8_pkg::t_beat beat;
    logic             push, pop, q_full, q_empty;

    u16u8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_unit  (s_tdata),
        .i_last  (s_tlast),
        .o_ready (s_tready),
        .i_q_full(q_full),
        .o_push  (push),
        .o_job   (push_job)
    );

    u16u8_queue #(
        .DEPTH(QDEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_job),
        .o_full (q_full),
        .i_pop  (pop),
        .o_data (pop_job),
        .o_empty(q_empty)
    );

    u16u8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_job    (pop_job),
        .o_pop    (pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_beat   (beat)
    );

    assign m_tdata = beat.data;
    assign m_tuser = {beat.status, beat.run_end};
    assign m_tlast = beat.str_end;

endmodule

`default_nettype wire

### test/utf16_to_utf8_transcoder_test.sv
// utf16_to_utf8_transcoder_test.sv
// self-checking bench: directed table then random strings, each byte checked
// against a utf-16 to utf-8 predictor; depends on u16u8_pkg and the transcoder
module utf16_to_utf8_transcoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT_TARGET = 132;
    localparam int PHASE_UNITS = 33;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 16;
    localparam int PRINT_CAP   = 40;
    localparam int DIR_ROWS    = 25;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
        logic        fixed;
        logic        one_result;
        logic [7:0]  data;
        logic        str_end;
        logic [1:0]  status;
    } t_dir_row;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;   // code_unit
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;               // out_byte
    logic [2:0]  m_tuser;               // last_of_run, status[1:0]
    logic        m_tlast;

    u16u8_pkg::t_beat utf8_pending[$];
    logic [9:0]  held_hi_bits   = '0;
    logic        hi_held        = 1'b0;
    logic        skipping_str   = 1'b0;
    int          n_errors       = 0;
    int          rx_stall       = 0;
    bit          tx_idle_en     = 1'b1;
    bit          rx_idle_en     = 1'b1;

    // extremes, every special case; fixed rows carry their expected beat, or none where one_result is clear
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{16'h0000, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'h007F, 1'b1, 1'b1, 1'b1, 8'h7F, 1'b1, u16u8_pkg::ST_OK},
        '{16'h0080, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'h07FF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'h0800, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hFFFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hD800, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hDC00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hDBFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hDFFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hDC00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, u16u8_pkg::ST_LONE_LOW},
        '{16'h0041, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hD800, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hDFFF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, u16u8_pkg::ST_LONE_LOW},
        '{16'hDBFF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, u16u8_pkg::ST_UNPAIRED},
        '{16'hD800, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'h0041, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, u16u8_pkg::ST_UNPAIRED},
        '{16'hDC00, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hD9AB, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hDA00, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, u16u8_pkg::ST_UNPAIRED},
        '{16'hE000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hD7FF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hD800, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK},
        '{16'hFFFF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, u16u8_pkg::ST_UNPAIRED},
        '{16'hAAAA, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, u16u8_pkg::ST_OK}
    };

    utf16_to_utf8_transcoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap(input bit en);
        int r;
        r = $urandom_range(0, 99);
        if (!en || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_code_point(input logic [20:0] cp, input logic last);
        logic [7:0] b [4];
        int n;
        if (cp <= 21'h7F) begin
            b[0] = cp[7:0];
            n = 1;
        end else if (cp <= 21'h7FF) begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
            n = 2;
        end else if (cp <= 21'hFFFF) begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            n = 3;
        end else begin
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++) begin
            utf8_pending.push_back('{data: b[k], run_end: (k == n - 1),
                                     str_end: (k == n - 1) && last,
                                     status: u16u8_pkg::ST_OK});
        end
    endfunction

    function automatic void push_fault(input logic [1:0] code, input logic last);
        utf8_pending.push_back('{data: 8'h00, run_end: 1'b1, str_end: 1'b1, status: code});
        hi_held = 1'b0;
        held_hi_bits = '0;
        skipping_str = !last;
    endfunction

    // advances the predicted state by one accepted code unit
    function automatic void transcode_unit(input logic [15:0] unit, input logic last,
                                           output bit dropped);
        logic is_hi;
        logic is_lo;
        is_hi = (unit[15:10] == u16u8_pkg::HIGH_TAG);
        is_lo = (unit[15:10] == u16u8_pkg::LOW_TAG);
        dropped = 1'b0;
        if (skipping_str) begin
            if (last) begin
                skipping_str = 1'b0;
            end
            dropped = 1'b1;
        end else if (hi_held) begin
            if (!is_lo) begin
                push_fault(u16u8_pkg::ST_UNPAIRED, last);
            end else begin
                hi_held = 1'b0;
                push_code_point(21'({held_hi_bits, unit[9:0]}) + u16u8_pkg::SUPP_BASE, last);
                held_hi_bits = '0;
            end
        end else if (is_lo) begin
            push_fault(u16u8_pkg::ST_LONE_LOW, last);
        end else if (is_hi) begin
            if (last) begin
                push_fault(u16u8_pkg::ST_UNPAIRED, 1'b1);
            end else begin
                held_hi_bits = unit[9:0];
                hi_held = 1'b1;
            end
        end else begin
            push_code_point({5'd0, unit}, last);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        n_errors++;
        if (n_errors <= PRINT_CAP) begin
            $display("%0t ns mismatch %s: got %h expected %h", $time, what, got, want);
        end
    endtask

    task automatic send_unit(input logic [15:0] unit, input logic last);
        int gap;
        gap = pick_gap(tx_idle_en);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= last;
        @(posedge i_clk);
        while (s_tready !== 1'b1) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : byte_sink
        int gap;
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            gap = pick_gap(rx_idle_en);
            if (gap > 0) begin
                m_tready <= 1'b0;
                rx_stall <= gap - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : byte_check
        u16u8_pkg::t_beat want;
        if (i_rst_n && m_tvalid === 1'b1 && m_tready) begin
            if (utf8_pending.size() == 0) begin
                report_mismatch("beat with nothing pending", {8'h00, m_tdata}, 16'h0000);
            end else begin
                want = utf8_pending.pop_front();
                if (m_tdata !== want.data) begin
                    report_mismatch("out_byte", {8'h00, m_tdata}, {8'h00, want.data});
                end
                if (m_tuser[0] !== want.run_end) begin
                    report_mismatch("last_of_run", {15'd0, m_tuser[0]}, {15'd0, want.run_end});
                end
                if (m_tlast !== want.str_end) begin
                    report_mismatch("string_done", {15'd0, m_tlast}, {15'd0, want.str_end});
                end
                if (m_tuser[2:1] !== want.status) begin
                    report_mismatch("status", {14'd0, m_tuser[2:1]}, {14'd0, want.status});
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("utf16_to_utf8_transcoder_test: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_dir_row         row;
        u16u8_pkg::t_beat scratch;
        bit          dropped;
        int          base;
        int          counted;
        int          mode;
        int          prev_mode;
        int          shape;
        int          n_chars;
        int          r;
        int          pos;
        logic [15:0] str_units[$];

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            send_unit(row.unit, row.last);
            base = utf8_pending.size();
            transcode_unit(row.unit, row.last, dropped);
            if (row.fixed) begin
                while (utf8_pending.size() > base) scratch = utf8_pending.pop_back();
                if (row.one_result) begin
                    utf8_pending.push_back('{data: row.data, run_end: 1'b1,
                                             str_end: row.str_end, status: row.status});
                end
            end
        end

        counted = 0;
        prev_mode = 0;
        while (counted < UNIT_TARGET) begin
            mode = (counted / PHASE_UNITS) % 4;
            if (mode != prev_mode) begin
                // drain the block before the next phase
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (utf8_pending.size() != 0) @(posedge i_clk);
                prev_mode = mode;
            end
            tx_idle_en = (mode == 0 || mode == 2);
            rx_idle_en = (mode == 0 || mode == 3);

            str_units.delete();
            shape = $urandom_range(0, 9);
            n_chars = $urandom_range(1, 6);
            if (shape == 8) begin
                repeat (n_chars) str_units.push_back(16'($urandom));
            end else if (shape == 9) begin
                repeat (n_chars) str_units.push_back(16'hD800 | 16'($urandom_range(0, 'h7FF)));
            end else begin
                repeat (n_chars) begin
                    r = $urandom_range(0, 99);
                    if (r < 35) begin
                        str_units.push_back(16'($urandom_range(0, 'h7F)));
                    end else if (r < 55) begin
                        str_units.push_back(16'($urandom_range('h80, 'h7FF)));
                    end else if (r < 75) begin
                        if ($urandom_range(0, 1)) begin
                            str_units.push_back(16'($urandom_range('h800, 'hD7FF)));
                        end else begin
                            str_units.push_back(16'($urandom_range('hE000, 'hFFFF)));
                        end
                    end else begin
                        str_units.push_back(16'hD800 | 16'($urandom_range(0, 'h3FF)));
                        str_units.push_back(16'hDC00 | 16'($urandom_range(0, 'h3FF)));
                    end
                end
                // broken string: stray low or high surrogate anywhere
                if (shape == 7) begin
                    pos = $urandom_range(0, str_units.size());
                    if ($urandom_range(0, 1)) begin
                        str_units.insert(pos, 16'hDC00 | 16'($urandom_range(0, 'h3FF)));
                    end else begin
                        str_units.insert(pos, 16'hD800 | 16'($urandom_range(0, 'h3FF)));
                    end
                end
            end

            foreach (str_units[k]) begin
                send_unit(str_units[k], k == str_units.size() - 1);
                transcode_unit(str_units[k], k == str_units.size() - 1, dropped);
                if (!dropped) begin
                    counted++;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (utf8_pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("utf16_to_utf8_transcoder_test: PASS");
        end else begin
            $display("utf16_to_utf8_transcoder_test: FAIL");
        end
        $finish;
    end

endmodule
